>>> design/icc_pkg.sv
package icc_pkg;

    // Command codes of an input item.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_CHECK = 1'b1;

    // Status codes of a result item.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_RANGE     = 2'd1;
    localparam logic [1:0] ST_ADDR_MISS = 2'd2;
    localparam logic [1:0] ST_COOK_MISS = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_CALL_KEY   = 1'b0;
    localparam logic CFG_SLOT_COUNT = 1'b1;

    // Odd multiplier that spreads the slot index over the cookie.
    localparam logic [31:0] COOKIE_MUL = 32'h9E37_79B9;

    // Input item.
    typedef struct packed {
        logic        command;
        logic [7:0]  slot;
        logic [31:0] target_addr;
    } icc_req_t;

    // Result item.
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] expected_addr;
    } icc_rsp_t;

    // One table entry: cookie and allowed target.
    typedef struct packed {
        logic [31:0] cookie;
        logic [31:0] target;
    } icc_entry_t;

    // Item held while its table read is outstanding.
    typedef struct packed {
        logic        command;
        logic        in_range;
        logic [31:0] target_addr;
        logic [31:0] mix;
    } icc_stage_t;

endpackage

>>> design/icc_ram.sv
module icc_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
)
(
    input  logic                                 clk,
    input  logic                                 wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                     wr_data,
    input  logic                                 rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Single write port and a registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/icc_store.sv
module icc_store
    import icc_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 wr_en,
    input  logic                                 rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] index,
    input  icc_entry_t                           wr_data,
    output icc_entry_t                           rd_data
);

    logic [DEPTH-1:0]         valid_reg;
    logic                     valid_rd_reg;
    logic [$bits(icc_entry_t)-1:0] ram_q;

    // Target and cookie share one memory word.
    icc_ram #(
        .WIDTH ($bits(icc_entry_t)),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (index),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (index),
        .rd_data (ram_q)
    );

    // One valid flag per entry stands in for clearing the memory at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            valid_rd_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[index] <= 1'b1;
            end
            if (rd_en)
            begin
                valid_rd_reg <= valid_reg[index];
            end
        end
    end

    // An entry never written reads as all zeros.
    assign rd_data = valid_rd_reg ? icc_entry_t'(ram_q) : '0;

endmodule

>>> design/icc_check.sv
module icc_check
    import icc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  icc_stage_t  stage_in,
    input  logic [31:0] call_key,
    input  icc_entry_t  entry,
    input  logic        rsp_stall,
    output logic        rsp_valid,
    output icc_rsp_t    rsp,
    output logic        busy
);

    logic       stage_valid_reg;
    logic       stage_valid_next;
    icc_stage_t stage_reg;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    icc_rsp_t   rsp_reg;
    icc_rsp_t   rsp_next;
    logic       advance;
    logic [31:0] cookie_exp;

    // The stage moves on when the output register is empty or being taken.
    assign advance          = stage_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign busy             = stage_valid_reg && !advance;
    assign stage_valid_next = accept || (stage_valid_reg && !advance);
    assign rsp_valid_next   = advance || (rsp_valid_reg && rsp_stall);

    // Cookie recomputed with the current key.
    assign cookie_exp = call_key ^ stage_reg.target_addr ^ stage_reg.mix;

    // Result of the item in the stage.
    always_comb
    begin
        rsp_next = '0;
        priority if (!stage_reg.in_range)
        begin
            rsp_next.status        = ST_RANGE;
            rsp_next.expected_addr = '0;
        end
        else if (stage_reg.command == CMD_LOAD)
        begin
            rsp_next.status        = ST_OK;
            rsp_next.expected_addr = stage_reg.target_addr;
        end
        else
        begin
            rsp_next.expected_addr = entry.target;
            priority if (stage_reg.target_addr == '0)
            begin
                rsp_next.status = ST_OK;
            end
            else if (stage_reg.target_addr != entry.target)
            begin
                rsp_next.status = ST_ADDR_MISS;
            end
            else if (entry.cookie != cookie_exp)
            begin
                rsp_next.status = ST_COOK_MISS;
            end
            else
            begin
                rsp_next.status = ST_OK;
            end
        end
    end

    // Control flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg <= stage_in;
        end
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> design/indirect_call_target_checker_unit.sv
// Channel   Direction  Handshake                Payload
// req       in         req_valid / req_stall    icc_req_t (command, slot, target_addr)
// rsp       out        rsp_valid / rsp_stall    icc_rsp_t (status, expected_addr)
// cfg       in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One item per cycle while the output is not stalled; an accepted item moves through
// the stage register into the output register. Loads write the table at the accept
// edge; checks read it there and compare the registered read data in the next cycle,
// so latency is set by the memory read port. Reset clears the key, the slot count and
// the per-entry valid flags, so every entry reads as zero without a clearing pass.
// A stalled output holds its item; the input stalls only when both stages are full.
module indirect_call_target_checker_unit
    import icc_pkg::*;
#(
    parameter int SLOT_DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  icc_req_t    req,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output icc_rsp_t    rsp,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int AW = SLOT_DEPTH > 1 ? $clog2(SLOT_DEPTH) : 1;

    logic [31:0] call_key_reg;
    logic [6:0]  slot_count_reg;
    logic        accept;
    logic        in_range;
    logic [31:0] mix;
    logic        busy;
    icc_stage_t  stage_in;
    icc_entry_t  wr_entry;
    icc_entry_t  rd_entry;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            call_key_reg   <= '0;
            slot_count_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_CALL_KEY:   call_key_reg   <= cfg_data;
                CFG_SLOT_COUNT: slot_count_reg <= cfg_data[6:0];
                default:        call_key_reg   <= call_key_reg;
            endcase
        end
    end

    // Accept side: range test and slot mix for the cookie.
    assign req_stall = busy;
    assign accept    = req_valid && !req_stall;
    assign in_range  = ({1'b0, req.slot} < {2'b00, slot_count_reg})
                    && ({1'b0, req.slot} < 9'(SLOT_DEPTH));
    assign mix       = 32'({24'd0, req.slot} * COOKIE_MUL);

    assign wr_entry.target = req.target_addr;
    assign wr_entry.cookie = call_key_reg ^ req.target_addr ^ mix;

    assign stage_in.command     = req.command;
    assign stage_in.in_range    = in_range;
    assign stage_in.target_addr = req.target_addr;
    assign stage_in.mix         = mix;

    // Slot table.
    icc_store #(
        .DEPTH (SLOT_DEPTH)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept && in_range && (req.command == CMD_LOAD)),
        .rd_en   (accept && in_range && (req.command == CMD_CHECK)),
        .index   (req.slot[AW-1:0]),
        .wr_data (wr_entry),
        .rd_data (rd_entry)
    );

    // Compare stage and output register.
    icc_check u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .stage_in   (stage_in),
        .call_key   (call_key_reg),
        .entry      (rd_entry),
        .rsp_stall  (rsp_stall),
        .rsp_valid  (rsp_valid),
        .rsp        (rsp),
        .busy       (busy)
    );

    // An out-of-range result never reports a stored target.
    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == ST_RANGE) |-> rsp.expected_addr == '0)
        else $error("out-of-range result carries a nonzero address");

    // A cookie mismatch only follows a matching, non-null address.
    a_cookie_addr: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == ST_COOK_MISS) |-> rsp.expected_addr != '0)
        else $error("cookie mismatch reported on a null address");

    // After an item is accepted, the output must come to hold a valid result, its own or an earlier stalled one.
    a_accept_seen: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 rsp_valid)
        else $error("accepted item did not reach the output");

endmodule
